FILE: hw/rtl/tfp_pkg.sv
// ----------------------------------------------------------------------------
// tfp_pkg
// Shared types and constants for the telemetry frame parser/decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tfp_pkg;

    typedef logic [7:0] t_byte;

    // Frame format
    localparam int unsigned MAX_PAYLOAD = 79;
    localparam int unsigned HEAD_DEPTH  = 11;
    localparam int unsigned REM_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned CNT_W       = $clog2(HEAD_DEPTH + 1);
    localparam int unsigned IDX_W       = $clog2(HEAD_DEPTH);

    localparam t_byte HEADER_BYTE = 8'hAA;
    localparam t_byte FN_COMMAND  = 8'hE0;
    localparam t_byte FN_PARAM    = 8'hE1;
    localparam t_byte SUB_RESET   = 8'h02;
    localparam t_byte SUB_READ    = 8'hE1;
    localparam t_byte RESET_KEY0  = 8'h00;
    localparam t_byte RESET_KEY1  = 8'hAA;
    localparam t_byte LEN_MAX     = 8'(MAX_PAYLOAD);

    // Register reset values
    localparam t_byte       OWN_ADDR_RST    = 8'h05;
    localparam t_byte       HOST_ADDR_RST   = 8'hAF;
    localparam logic [15:0] PARAM_LIMIT_RST = 16'd100;

    // Register indexes (byte address / 4)
    localparam int unsigned PADDR_W = 4;
    localparam logic [1:0] REG_OWN_ADDR    = 2'd0;
    localparam logic [1:0] REG_HOST_ADDR   = 2'd1;
    localparam logic [1:0] REG_PARAM_LIMIT = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_COMMAND = 2'd0;
    localparam logic [1:0] ST_PARAM   = 2'd1;
    localparam logic [1:0] ST_CSUM    = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    // Front-to-back queue
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int unsigned Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        t_byte       own_address;
        t_byte       host_address;
        logic [15:0] param_limit;
    } t_cfg;

    // Classified frame passed from front to back
    typedef struct packed {
        logic [1:0]                 status;
        t_byte [HEAD_DEPTH-1:0]     head;
    } t_frame;

    typedef struct packed {
        logic [1:0]         status;
        t_byte              sub_function;
        logic [15:0]        word_one;
        logic [15:0]        word_two;
        logic [15:0]        word_three;
        logic [15:0]        word_four;
        logic [15:0]        word_five;
        logic [15:0]        param_index;
        logic signed [31:0] param_value;
        logic               param_in_range;
        logic               reset_request;
        logic               read_request;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/tfp_if.sv
// ----------------------------------------------------------------------------
// tfp_if
// Valid/ready channel interfaces for received bytes and decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfp_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [7:0]         sub_function;
    logic [15:0]        word_one;
    logic [15:0]        word_two;
    logic [15:0]        word_three;
    logic [15:0]        word_four;
    logic [15:0]        word_five;
    logic [15:0]        param_index;
    logic signed [31:0] param_value;
    logic               param_in_range;
    logic               reset_request;
    logic               read_request;

    modport source (output valid, output status, output sub_function, output word_one,
                    output word_two, output word_three, output word_four,
                    output word_five, output param_index, output param_value,
                    output param_in_range, output reset_request,
                    output read_request, input ready);
    modport sink   (input valid, input status, input sub_function, input word_one,
                    input word_two, input word_three, input word_four,
                    input word_five, input param_index, input param_value,
                    input param_in_range, input reset_request,
                    input read_request, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/telemetry_frame_parser_decoder.sv
// ----------------------------------------------------------------------------
// telemetry_frame_parser_decoder
// Ground-station serial frame receiver: parses header, source, destination,
// function, length, payload and checksum, and reports one result per frame.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake        Moves
//  --------  ---  ---------------  ------------------------------------------
//  i_rx      in   valid/ready      one received byte per request
//  o_res     out  valid/ready      one decoded result per complete frame
//  APB       in   psel/penable     own_address @0x0, host_address @0x4,
//                                  param_limit @0x8 (write and read back)
//
//  One byte per cycle, sustained, but for the stall below. A frame's result
//  passes through the queue, then the formatter's output register, to o_res.
//  A two-entry queue sits between parser and formatter; the parser only
//  stalls on a checksum byte when that queue is full, and the formatter's
//  output register refills in the same cycle it is taken.
//  Reset is synchronous, active low, and returns the parser to the hunt.
// ----------------------------------------------------------------------------
`default_nettype none

module telemetry_frame_parser_decoder (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    tfp_in_if.sink                       i_rx,
    tfp_out_if.source                    o_res,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [tfp_pkg::PADDR_W-1:0]   paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import tfp_pkg::*;

    // Configuration registers
    t_byte       r_own_address;
    t_byte       r_host_address;
    logic [15:0] r_param_limit;
    logic        cfg_wr;
    t_cfg        cfg;

    // Front/back link
    logic   push, push_ready, pop, pop_valid;
    t_frame push_data, pop_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address  <= OWN_ADDR_RST;
            r_host_address <= HOST_ADDR_RST;
            r_param_limit  <= PARAM_LIMIT_RST;
        end else if (cfg_wr) begin
            // word-aligned decode; unknown offsets are dropped
            unique case (paddr[3:2])
                REG_OWN_ADDR:    r_own_address  <= pwdata[7:0];
                REG_HOST_ADDR:   r_host_address <= pwdata[7:0];
                REG_PARAM_LIMIT: r_param_limit  <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_OWN_ADDR:    prdata = {24'd0, r_own_address};
            REG_HOST_ADDR:   prdata = {24'd0, r_host_address};
            REG_PARAM_LIMIT: prdata = {16'd0, r_param_limit};
            default:         prdata = '0;
        endcase
    end

    assign cfg.own_address  = r_own_address;
    assign cfg.host_address = r_host_address;
    assign cfg.param_limit  = r_param_limit;

    // Parser: frames are classified as the checksum byte arrives
    tfp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (i_rx),
        .i_cfg        (cfg),
        .o_push       (push),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    tfp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data)
    );

    // Formatter: builds result words and drives the output register
    tfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_data  (pop_data),
        .o_pop       (pop),
        .i_cfg       (cfg),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/tfp_front.sv
// ----------------------------------------------------------------------------
// tfp_front
// Byte parser: hunts for frames, accumulates checksum, captures the payload
// head and classifies each completed frame into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tfp_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    tfp_in_if.sink          i_rx,
    input  tfp_pkg::t_cfg   i_cfg,
    output logic            o_push,
    output tfp_pkg::t_frame o_push_data,
    input  wire             i_push_ready
);
    import tfp_pkg::*;

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_SRC     = 3'd1;
    localparam logic [2:0] PH_DST     = 3'd2;
    localparam logic [2:0] PH_FUNC    = 3'd3;
    localparam logic [2:0] PH_LEN     = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_CHECK   = 3'd6;

    logic [2:0]             r_phase, n_phase;
    logic [REM_W-1:0]       r_rem, n_rem;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    t_byte                  r_sum, n_sum;
    t_byte                  r_dest, n_dest;
    t_byte                  r_func, n_func;
    t_byte [HEAD_DEPTH-1:0] r_head, n_head;
    logic                   take;
    t_byte                  b;
    t_byte                  sum_add;

    // Only the checksum byte needs queue room.
    assign i_rx.ready = (r_phase != PH_CHECK) || i_push_ready;
    assign take       = i_rx.valid && i_rx.ready;
    assign b          = i_rx.rx_byte;
    assign sum_add    = r_sum + b;

    always_comb begin
        n_phase = r_phase;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        n_dest  = r_dest;
        n_func  = r_func;
        n_head  = r_head;
        o_push  = 1'b0;
        if (take) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (b == HEADER_BYTE) begin
                        n_sum   = b;
                        n_phase = PH_SRC;
                    end
                end
                PH_SRC: begin
                    if (b == i_cfg.host_address) begin
                        n_sum   = sum_add;
                        n_phase = PH_DST;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_DST: begin
                    n_dest  = b;
                    n_sum   = sum_add;
                    n_phase = PH_FUNC;
                end
                PH_FUNC: begin
                    n_func  = b;
                    n_sum   = sum_add;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_sum   = sum_add;
                    // zero remaining marks a bad length: next byte is dropped
                    n_rem   = (b != 8'd0 && b <= LEN_MAX) ? REM_W'(b) : '0;
                    n_cnt   = '0;
                    n_head  = '0;
                    n_phase = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    if (r_rem == '0) begin
                        n_phase = PH_HUNT;
                    end else begin
                        if (r_cnt < CNT_W'(HEAD_DEPTH)) begin
                            n_head[r_cnt[IDX_W-1:0]] = b;
                            n_cnt = r_cnt + 1'b1;
                        end
                        n_sum = sum_add;
                        n_rem = r_rem - 1'b1;
                        if (r_rem == REM_W'(1)) begin
                            n_phase = PH_CHECK;
                        end
                    end
                end
                PH_CHECK: begin
                    o_push  = 1'b1;
                    n_phase = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_comb begin
        o_push_data.head = r_head;
        if (r_sum != b) begin
            o_push_data.status = ST_CSUM;
        end else if (r_dest != i_cfg.own_address) begin
            o_push_data.status = ST_IGNORED;
        end else if (r_func == FN_COMMAND) begin
            o_push_data.status = ST_COMMAND;
        end else if (r_func == FN_PARAM) begin
            o_push_data.status = ST_PARAM;
        end else begin
            o_push_data.status = ST_IGNORED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_rem   <= '0;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_dest <= n_dest;
        r_func <= n_func;
        r_head <= n_head;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tfp_queue.sv
// ----------------------------------------------------------------------------
// tfp_queue
// Short FIFO of classified frames between parser and result formatter.
// ----------------------------------------------------------------------------
`default_nettype none

module tfp_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  tfp_pkg::t_frame i_push_data,
    output logic            o_push_ready,
    input  wire             i_pop,
    output logic            o_pop_valid,
    output tfp_pkg::t_frame o_pop_data
);
    import tfp_pkg::*;

    t_frame               r_mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 do_push, do_pop;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        if (p == Q_PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign o_push_ready = (r_count != Q_CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tfp_back.sv
// ----------------------------------------------------------------------------
// tfp_back
// Result formatter: decodes a classified frame into result fields and holds
// them in the output register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tfp_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_pop_valid,
    input  tfp_pkg::t_frame i_pop_data,
    output logic            o_pop,
    input  tfp_pkg::t_cfg   i_cfg,
    tfp_out_if.source       o_res
);
    import tfp_pkg::*;

    logic    r_valid;
    t_result r_res;
    t_result n_res;
    t_byte [HEAD_DEPTH-1:0] h;

    assign h     = i_pop_data.head;
    assign o_pop = i_pop_valid && (!r_valid || o_res.ready);

    always_comb begin
        n_res        = '0;
        n_res.status = i_pop_data.status;
        unique case (i_pop_data.status)
            ST_COMMAND: begin
                n_res.sub_function  = h[0];
                n_res.word_one      = {h[1], h[2]};
                n_res.word_two      = {h[3], h[4]};
                n_res.word_three    = {h[5], h[6]};
                n_res.word_four     = {h[7], h[8]};
                n_res.word_five     = {h[9], h[10]};
                n_res.reset_request = (h[0] == SUB_RESET) && (h[1] == RESET_KEY0)
                                      && (h[2] == RESET_KEY1);
                n_res.read_request  = (h[0] == SUB_READ);
            end
            ST_PARAM: begin
                n_res.param_index    = {h[0], h[1]};
                n_res.param_value    = $signed({h[2], h[3], h[4], h[5]});
                n_res.param_in_range = ({h[0], h[1]} <= i_cfg.param_limit);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.status         = r_res.status;
    assign o_res.sub_function   = r_res.sub_function;
    assign o_res.word_one       = r_res.word_one;
    assign o_res.word_two       = r_res.word_two;
    assign o_res.word_three     = r_res.word_three;
    assign o_res.word_four      = r_res.word_four;
    assign o_res.word_five      = r_res.word_five;
    assign o_res.param_index    = r_res.param_index;
    assign o_res.param_value    = r_res.param_value;
    assign o_res.param_in_range = r_res.param_in_range;
    assign o_res.reset_request  = r_res.reset_request;
    assign o_res.read_request   = r_res.read_request;

endmodule

`default_nettype wire

FILE: dv/tfp_frame_checker.sv
// ----------------------------------------------------------------------------
// tfp_frame_checker
// Watches the byte channel, the result channel and the register port. Tracks
// the frame parser in lockstep with the block and checks each decoded result,
// field by field, against the oldest predicted one.
// ----------------------------------------------------------------------------
module tfp_frame_checker
    import tfp_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    tfp_in_if                 rx_mon,
    tfp_out_if                res_mon,
    input  wire               i_psel,
    input  wire               i_penable,
    input  wire               i_pwrite,
    input  wire               i_pready,
    input  wire [PADDR_W-1:0] i_paddr,
    input  wire [31:0]        i_pwdata,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        PH_HUNT, PH_SOURCE, PH_DEST, PH_FUNC, PH_LEN, PH_PAYLOAD, PH_CHECK
    } t_phase;

    // register copies
    t_byte       own_address;
    t_byte       host_address;
    logic [15:0] param_limit;

    // parser copy
    t_phase           phase;
    logic [REM_W-1:0] bytes_left;
    logic [6:0]       payload_seen;
    t_byte            frame_sum;
    t_byte            dest_seen;
    t_byte            func_seen;
    t_byte            head [HEAD_DEPTH];

    t_result decoded_frames [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_result frame_verdict(input t_byte check);
        t_result r;
        r = '0;
        if (frame_sum != check) begin
            r.status = ST_CSUM;
        end else if (dest_seen != own_address) begin
            r.status = ST_IGNORED;
        end else if (func_seen == FN_COMMAND) begin
            r.status        = ST_COMMAND;
            r.sub_function  = head[0];
            r.word_one      = {head[1], head[2]};
            r.word_two      = {head[3], head[4]};
            r.word_three    = {head[5], head[6]};
            r.word_four     = {head[7], head[8]};
            r.word_five     = {head[9], head[10]};
            r.reset_request = (head[0] == SUB_RESET) && (head[1] == RESET_KEY0) &&
                              (head[2] == RESET_KEY1);
            r.read_request  = (head[0] == SUB_READ);
        end else if (func_seen == FN_PARAM) begin
            r.status         = ST_PARAM;
            r.param_index    = {head[0], head[1]};
            r.param_value    = {head[2], head[3], head[4], head[5]};
            r.param_in_range = ({head[0], head[1]} <= param_limit);
        end else begin
            r.status = ST_IGNORED;
        end
        return r;
    endfunction

    task automatic take_byte(input t_byte b);
        case (phase)
            PH_HUNT: begin
                if (b == HEADER_BYTE) begin
                    frame_sum = b;
                    phase     = PH_SOURCE;
                end
            end
            PH_SOURCE: begin
                // a wrong source drops back to the hunt without a header look
                if (b == host_address) begin
                    frame_sum += b;
                    phase      = PH_DEST;
                end else begin
                    phase = PH_HUNT;
                end
            end
            PH_DEST: begin
                dest_seen  = b;
                frame_sum += b;
                phase      = PH_FUNC;
            end
            PH_FUNC: begin
                func_seen  = b;
                frame_sum += b;
                phase      = PH_LEN;
            end
            PH_LEN: begin
                frame_sum   += b;
                bytes_left   = (b >= 8'd1 && b <= LEN_MAX) ? REM_W'(b) : '0;
                payload_seen = '0;
                foreach (head[k]) head[k] = '0;
                phase        = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                // bad length: this byte is swallowed
                if (bytes_left == '0) begin
                    phase = PH_HUNT;
                end else begin
                    if (payload_seen < HEAD_DEPTH) head[payload_seen] = b;
                    payload_seen++;
                    frame_sum += b;
                    bytes_left--;
                    if (bytes_left == '0) phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                phase = PH_HUNT;
                decoded_frames.push_back(frame_verdict(b));
            end
            default: phase = PH_HUNT;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            own_address  = OWN_ADDR_RST;
            host_address = HOST_ADDR_RST;
            param_limit  = PARAM_LIMIT_RST;
            phase        = PH_HUNT;
            bytes_left   = '0;
            payload_seen = '0;
            frame_sum    = '0;
            dest_seen    = '0;
            func_seen    = '0;
            foreach (head[k]) head[k] = '0;
            decoded_frames.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[PADDR_W-1:2])
                    REG_OWN_ADDR:    own_address  = i_pwdata[7:0];
                    REG_HOST_ADDR:   host_address = i_pwdata[7:0];
                    REG_PARAM_LIMIT: param_limit  = i_pwdata[15:0];
                    default: ;
                endcase
            end
            // results first: one leaving now belongs to an earlier byte
            if (res_mon.valid && res_mon.ready) begin
                if (decoded_frames.size() == 0) begin
                    $error("result with no frame pending");
                    o_fail_count++;
                end else begin
                    want = decoded_frames.pop_front();
                    check_field("status", want.status, res_mon.status);
                    check_field("sub_function", want.sub_function, res_mon.sub_function);
                    check_field("word_one", want.word_one, res_mon.word_one);
                    check_field("word_two", want.word_two, res_mon.word_two);
                    check_field("word_three", want.word_three, res_mon.word_three);
                    check_field("word_four", want.word_four, res_mon.word_four);
                    check_field("word_five", want.word_five, res_mon.word_five);
                    check_field("param_index", want.param_index, res_mon.param_index);
                    check_field("param_value", want.param_value, res_mon.param_value);
                    check_field("param_in_range", want.param_in_range,
                                res_mon.param_in_range);
                    check_field("reset_request", want.reset_request,
                                res_mon.reset_request);
                    check_field("read_request", want.read_request, res_mon.read_request);
                end
            end
            if (rx_mon.valid && rx_mon.ready) take_byte(rx_mon.rx_byte);
        end
        o_pending = decoded_frames.size();
    end

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Frame parser testbench: sends serial bytes as well-formed, corrupted and
// broken frames under several register settings, with random idling on both
// channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tfp_pkg::*;

    typedef t_byte t_bytes [$];

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;    // result passes the queue and the output register after its checksum
    localparam int HOLD_CYCLES  = 250;  // long receiver hold-off
    localparam int IDLE_PCT     = 34;

    logic i_clk;
    logic i_rst_n;

    tfp_in_if  rx_if ();
    tfp_out_if res_if ();

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int fail_count;
    int pending;

    // Stimulus-side view of the registers, used to build frames that pass
    t_byte       own_addr;
    t_byte       host_addr;
    logic [15:0] limit;

    int items_sent;    // bytes that the parser actually looks at
    bit no_idle;       // both sides run flat out while set
    bit stall_req;     // asks the result side for one long hold-off

    telemetry_frame_parser_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tfp_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .rx_mon       (rx_if),
        .res_mon      (res_if),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Result side. Random stalls unless no_idle is set; a stall_req turns
    // into one long hold-off counted here, while the sender keeps pushing
    // bytes so the internal queue fills and the byte input backs up.
    initial begin : result_sink
        int hold_left;
        hold_left    = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (stall_req) begin
                res_if.ready <= 1'b0;
                hold_left = HOLD_CYCLES - 1;
                stall_req = 1'b0;
            end else begin
                res_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // All tasks below start and end on a falling edge.

    // Register write: setup cycle, then access cycle. The extra edge at the
    // end keeps back-to-back writes from driving psel twice in one step.
    task automatic cfg_write(input logic [1:0] reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(input t_byte own, input t_byte host, input logic [15:0] lim);
        cfg_write(REG_OWN_ADDR, 32'(own));
        cfg_write(REG_HOST_ADDR, 32'(host));
        cfg_write(REG_PARAM_LIMIT, 32'(lim));
        own_addr  = own;
        host_addr = host;
        limit     = lim;
    endtask

    // One byte request. valid stays high into the next call, so a run of
    // calls with no idle streams one byte per cycle while ready is high.
    task automatic send_byte(input t_byte value, input bit ignored = 1'b0);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            rx_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= value;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (!ignored) items_sent++;
    endtask

    // Sender pause: drop valid and wait for every predicted result, plus
    // the pipeline depth so nothing is still in flight.
    task automatic wait_drained();
        rx_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_frame(input t_byte dest, input t_byte fn, input t_bytes body,
                              input bit corrupt);
        t_byte sum;
        sum = HEADER_BYTE + host_addr + dest + fn + t_byte'(body.size());
        foreach (body[k]) sum += body[k];
        send_byte(HEADER_BYTE);
        send_byte(host_addr);
        send_byte(dest);
        send_byte(fn);
        send_byte(t_byte'(body.size()));
        foreach (body[k]) send_byte(body[k]);
        send_byte(corrupt ? t_byte'(sum + $urandom_range(1, 255)) : sum);
    endtask

    // Random payload with the interesting leads planted often: reset key
    // (whole and broken), read request, indexes around the limit, and the
    // signed value extremes.
    function automatic t_bytes random_payload(input t_byte fn, input int len);
        t_bytes      body;
        t_byte       lead [6];
        logic [15:0] index;
        logic [31:0] value;
        foreach (lead[k]) lead[k] = t_byte'($urandom);
        if (fn == FN_COMMAND) begin
            case ($urandom_range(7))
                0: {lead[0], lead[1], lead[2]} = {SUB_RESET, RESET_KEY0, RESET_KEY1};
                1: {lead[0], lead[1]} = {SUB_RESET, RESET_KEY0};
                2: {lead[0], lead[2]} = {SUB_RESET, RESET_KEY1};
                3, 4: lead[0] = SUB_READ;
                default: ;
            endcase
        end else if (fn == FN_PARAM) begin
            index = {lead[0], lead[1]};
            case ($urandom_range(5))
                0: index = limit;
                1: index = limit + 16'd1;
                2: index = '0;
                3: index = '1;
                default: ;
            endcase
            value = {lead[2], lead[3], lead[4], lead[5]};
            case ($urandom_range(7))
                0: value = 32'h8000_0000;
                1: value = 32'h7FFF_FFFF;
                2: value = '1;
                default: ;
            endcase
            {lead[0], lead[1]} = index;
            {lead[2], lead[3], lead[4], lead[5]} = value;
        end
        for (int k = 0; k < len; k++) body.push_back(k < 6 ? lead[k] : t_byte'($urandom));
        return body;
    endfunction

    task automatic random_frame(input bit corrupt, input int max_len);
        t_byte dest;
        t_byte fn;
        int    len;
        int    pick;
        dest = ($urandom_range(99) < 85) ? own_addr : t_byte'($urandom);
        pick = $urandom_range(99);
        fn   = (pick < 40) ? FN_COMMAND : (pick < 80) ? FN_PARAM : t_byte'($urandom);
        // mostly short frames; a few long ones and some at the maximum
        pick = $urandom_range(99);
        len  = (pick < 3) ? int'(LEN_MAX) :
               (pick < 10) ? $urandom_range(max_len, int'(LEN_MAX)) :
               $urandom_range(1, max_len);
        send_frame(dest, fn, random_payload(fn, len), corrupt);
    endtask

    // Length out of range: the byte after it is swallowed, no result.
    task automatic send_bad_length(input t_byte len_byte);
        send_byte(HEADER_BYTE);
        send_byte(host_addr);
        send_byte(own_addr);
        send_byte(FN_COMMAND);
        send_byte(len_byte);
        send_byte(t_byte'($urandom));
    endtask

    // Header then a source other than the host. The source byte may itself
    // be 0xAA, which must not restart a frame.
    task automatic send_wrong_source();
        t_byte src;
        do src = t_byte'($urandom); while (src == host_addr);
        send_byte(HEADER_BYTE);
        send_byte(src);
    endtask

    // Mix: mostly good frames with random content, some with a bad checksum,
    // the rest bad lengths, broken headers and idle-line noise (never 0xAA,
    // so the parser stays in the hunt and those bytes are plain ignored).
    task automatic random_traffic(input int n_items);
        int    start;
        int    kind;
        t_byte junk;
        start = items_sent;
        while (items_sent - start < n_items) begin
            kind = $urandom_range(99);
            if (kind < 68) begin
                random_frame(1'b0, 12);
            end else if (kind < 78) begin
                random_frame(1'b1, 12);
            end else if (kind < 86) begin
                case ($urandom_range(3))
                    0: send_bad_length(8'h00);
                    1: send_bad_length(LEN_MAX + 8'd1);
                    2: send_bad_length(8'hFF);
                    default: send_bad_length(t_byte'($urandom_range(int'(LEN_MAX) + 1, 255)));
                endcase
            end else if (kind < 93) begin
                send_wrong_source();
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    do junk = t_byte'($urandom); while (junk == HEADER_BYTE);
                    send_byte(junk, 1'b1);
                end
            end
        end
    endtask

    initial begin
        t_bytes body;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        items_sent    = 0;
        no_idle       = 1'b0;
        stall_req     = 1'b0;
        own_addr      = OWN_ADDR_RST;
        host_addr     = HOST_ADDR_RST;
        limit         = PARAM_LIMIT_RST;

        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, on reset register values.
        // Command with the full PID-reset key.
        body = '{SUB_RESET, RESET_KEY0, RESET_KEY1};
        send_frame(own_addr, FN_COMMAND, body, 1'b0);
        // Parameter write: index one past the limit, most negative value.
        body = '{8'h00, 8'h65, 8'h80, 8'h00, 8'h00, 8'h00};
        send_frame(own_addr, FN_PARAM, body, 1'b0);
        // Broken header and a length just past the maximum.
        send_wrong_source();
        send_bad_length(LEN_MAX + 8'd1);

        random_traffic(90);
        wait_drained();

        // Low extremes: index zero is the only one in range.
        set_config(8'h00, 8'h00, 16'h0000);
        random_traffic(90);
        wait_drained();

        // High extremes, plus the long hold-off on the result side. Short
        // frames back to back fill the internal queue quickly.
        set_config(8'hFF, 8'hFF, 16'hFFFF);
        stall_req = 1'b1;
        no_idle   = 1'b1;
        repeat (30) send_frame(own_addr, FN_COMMAND,
                               random_payload(FN_COMMAND, $urandom_range(1, 2)), 1'b0);
        no_idle = 1'b0;
        random_traffic(50);
        wait_drained();

        // Random registers with a long stretch of no idling on either side.
        set_config(t_byte'($urandom), t_byte'($urandom), 16'($urandom));
        no_idle = 1'b1;
        random_traffic(90);
        no_idle = 1'b0;
        wait_drained();

        // Host equal to the header byte.
        set_config(OWN_ADDR_RST, HEADER_BYTE, 16'($urandom));
        random_traffic(90);
        wait_drained();

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
